// File: design/e2q_pkg.sv
// Package for the Euler-angle to quaternion block.
// Holds the CORDIC constants, the arctangent table and the fixed-point helpers.
// No dependencies.
package e2q_pkg;

  localparam int unsigned FRAC = 30;
  localparam int unsigned CW = 34;
  localparam int unsigned PW = 32;

  typedef logic signed [CW-1:0] cval_t;

  localparam logic signed [CW-1:0] K_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_Q = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q = 34'sd1686629713;

  function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'h3243F6A8;
      5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;
      5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;
      5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;
      5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;
      5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return cval_t'({2'b00, v});
  endfunction

  // Product of two 30-fraction values, rounded to nearest (ties up).
  function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b + (68'sd1 <<< (FRAC - 1));
    return cval_t'(p >>> FRAC);
  endfunction

endpackage

// File: design/euler_to_quaternion.sv
// Euler roll, pitch and yaw to a unit quaternion, fully pipelined.
// One new transfer is taken every cycle while no stall holds the pipeline; the
// path runs through the CORDIC input register, one CORDIC stage per iteration, two
// product stages and the sum/round output register. A stall freezes the whole
// pipeline. Uses e2q_pkg, e2q_cordic and e2q_combine.
module euler_to_quaternion #(
  parameter int ANGLE_WIDTH = 16,
  parameter int OUT_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OUT_WIDTH-1:0]   quat_w_o,
  output logic signed [OUT_WIDTH-1:0]   quat_x_o,
  output logic signed [OUT_WIDTH-1:0]   quat_y_o,
  output logic signed [OUT_WIDTH-1:0]   quat_z_o
);
  import e2q_pkg::*;

  localparam int NS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int DEPTH = NS + 4;

  logic [DEPTH-1:0] vld_q;
  logic en;
  cval_t cr, sr, cp, sp, cy, sy;

  // The pipeline advances unless a finished result is held by the sink.
  assign en = !(vld_q[DEPTH-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(roll_angle_i), .cos_o(cr), .sin_o(sr));
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(pitch_angle_i), .cos_o(cp), .sin_o(sp));
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(yaw_angle_i), .cos_o(cy), .sin_o(sy));

  e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_combine (
    .clk_i(clk_i), .en_i(en),
    .cr_i(cr), .sr_i(sr), .cp_i(cp), .sp_i(sp), .cy_i(cy), .sy_i(sy),
    .w_o(quat_w_o), .x_o(quat_x_o), .y_o(quat_y_o), .z_o(quat_z_o));

  assign out_valid_o = vld_q[DEPTH-1];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quat_w_o))
    else $error("held result changed");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_w_o != {1'b1, {(OUT_WIDTH-1){1'b0}}})
    else $error("component out of range");

endmodule

// File: design/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: one register stage per iteration.
// Gives the cosine and sine of half the input angle. Uses e2q_pkg.
module e2q_cordic #(
  parameter int ANGLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output e2q_pkg::cval_t                cos_o,
  output e2q_pkg::cval_t                sin_o
);
  import e2q_pkg::*;

  localparam int NS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  cval_t x_q [NS+1];
  cval_t y_q [NS+1];
  cval_t z_q [NS+1];
  logic  n_q [NS+1];

  cval_t h_d;
  cval_t hr_d;
  logic  n_d;

  always_comb begin
    h_d = cval_t'(angle_i) <<< (32 - ANGLE_WIDTH);
    hr_d = h_d;
    n_d = 1'b0;
    if (h_d > HALF_PI_Q) begin
      hr_d = h_d - PI_Q;
      n_d = 1'b1;
    end else if (h_d < -HALF_PI_Q) begin
      hr_d = h_d + PI_Q;
      n_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= K_GAIN;
      y_q[0] <= '0;
      z_q[0] <= hr_d;
      n_q[0] <= n_d;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= n_q[i];
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_entry(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_entry(5'(i));
        end
      end
    end
  end

  assign cos_o = n_q[NS] ? -x_q[NS] : x_q[NS];
  assign sin_o = n_q[NS] ? -y_q[NS] : y_q[NS];

endmodule

// File: design/e2q_combine.sv
// Multiplier stages that form the quaternion from the six half-angle terms.
// Two product stages, then sum, round and clamp. Uses e2q_pkg.
module e2q_combine #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  e2q_pkg::cval_t              cr_i,
  input  e2q_pkg::cval_t              sr_i,
  input  e2q_pkg::cval_t              cp_i,
  input  e2q_pkg::cval_t              sp_i,
  input  e2q_pkg::cval_t              cy_i,
  input  e2q_pkg::cval_t              sy_i,
  output logic signed [OUT_WIDTH-1:0] w_o,
  output logic signed [OUT_WIDTH-1:0] x_o,
  output logic signed [OUT_WIDTH-1:0] y_o,
  output logic signed [OUT_WIDTH-1:0] z_o
);
  import e2q_pkg::*;

  localparam int SH = 32 - OUT_WIDTH;
  localparam logic signed [CW:0] ONE = (CW+1)'(1) <<< (OUT_WIDTH - 2);

  cval_t cc_q, ss_q, cs_q, sc_q, cy_q, sy_q;
  cval_t p_q [8];
  logic signed [OUT_WIDTH-1:0] w_q, x_q, y_q, z_q;

  function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [CW:0] v);
    logic signed [CW+1:0] r;
    r = (CW+2)'(v);
    if (SH > 0) begin
      r = (r + ((CW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
    end
    if (r > (CW+2)'(ONE)) r = (CW+2)'(ONE);
    if (r < -(CW+2)'(ONE)) r = -(CW+2)'(ONE);
    return r[OUT_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= mulq(cr_i, cp_i);
      ss_q <= mulq(sr_i, sp_i);
      cs_q <= mulq(cr_i, sp_i);
      sc_q <= mulq(sr_i, cp_i);
      cy_q <= cy_i;
      sy_q <= sy_i;
      p_q[0] <= mulq(cc_q, cy_q);
      p_q[1] <= mulq(ss_q, sy_q);
      p_q[2] <= mulq(cs_q, cy_q);
      p_q[3] <= mulq(sc_q, sy_q);
      p_q[4] <= mulq(cc_q, sy_q);
      p_q[5] <= mulq(ss_q, cy_q);
      p_q[6] <= mulq(sc_q, cy_q);
      p_q[7] <= mulq(cs_q, sy_q);
      w_q <= to_out((CW+1)'(p_q[0]) + (CW+1)'(p_q[1]));
      x_q <= to_out((CW+1)'(p_q[2]) + (CW+1)'(p_q[3]));
      y_q <= to_out((CW+1)'(p_q[4]) - (CW+1)'(p_q[5]));
      z_q <= to_out((CW+1)'(p_q[6]) - (CW+1)'(p_q[7]));
    end
  end

  assign w_o = w_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule
